@@ hw/rtl/rdsc_pkg.sv @@
package rdsc_pkg;

	// Time units
	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned SECS_PER_HOUR = 60 * SECS_PER_MIN;
	localparam int unsigned SECS_PER_DAY  = 24 * SECS_PER_HOUR;
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned DAYS_PER_LEAP = 366;
	localparam int unsigned DAYS_PER_QUAD = 3 * DAYS_PER_YEAR + DAYS_PER_LEAP;

	// Cycles from an accepted request to its result strobe
	localparam int unsigned LATENCY = 9;

	// Constant dividers: drop the power of two, then multiply by a truncated
	// reciprocal of the odd part. The estimate is at most one low.
	localparam int unsigned DAY_SHIFT  = 7;
	localparam int unsigned DAY_DIV    = SECS_PER_DAY / (1 << DAY_SHIFT);
	localparam int unsigned DAY_K      = 24;
	localparam int unsigned DAY_RECIP  = (1 << DAY_K) / DAY_DIV;

	localparam int unsigned QUAD_K     = 15;
	localparam int unsigned QUAD_RECIP = (1 << QUAD_K) / DAYS_PER_QUAD;

	localparam int unsigned HOUR_SHIFT = 4;
	localparam int unsigned HOUR_DIV   = SECS_PER_HOUR / (1 << HOUR_SHIFT);
	localparam int unsigned HOUR_K     = 13;
	localparam int unsigned HOUR_RECIP = (1 << HOUR_K) / HOUR_DIV;

	localparam int unsigned MIN_SHIFT  = 2;
	localparam int unsigned MIN_DIV    = SECS_PER_MIN / (1 << MIN_SHIFT);
	localparam int unsigned MIN_K      = 10;
	localparam int unsigned MIN_RECIP  = (1 << MIN_K) / MIN_DIV;

	// Request kinds
	localparam logic KIND_TO_SECONDS = 1'b0;
	localparam logic KIND_TO_DATE    = 1'b1;

	// First day of each month within the year; entry 12 is the year length
	localparam logic [8:0] MONTH_START_COMMON [13] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};
	localparam logic [8:0] MONTH_START_LEAP [13] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
	};

	typedef struct packed {
		logic        kind;
		logic [6:0]  in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [4:0]  in_hour;
		logic [5:0]  in_minute;
		logic [5:0]  in_second;
		logic [30:0] seconds_in;
	} req_t;

	typedef struct packed {
		logic [30:0] seconds_out;
		logic [6:0]  out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
	} rsp_t;

	// Day of year on which month idx (0 = January) starts; idx stays in 0..12
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] val;
		val = leap ? MONTH_START_LEAP[idx] : MONTH_START_COMMON[idx];
		return val;
	endfunction

endpackage

@@ hw/rtl/rtc_date_seconds_convert_unit.sv @@
// Calendar <-> seconds converter for a real-time clock counting from
// 2000-01-01 00:00:00. A request with kind 0 packs year (0 = 2000), month,
// day, hour, minute and second into a 31-bit seconds count (taken modulo
// 2^31); kind 1 unpacks a seconds count into a calendar date. Every year that
// is a multiple of four is a leap year, with no century rule. Inputs are not
// range checked. The block is a nine-stage pipeline: a request is taken on
// any cycle with start high (busy stays low), and its result appears on rsp
// from the last stage, with done high for a single cycle. One request per
// cycle is sustained. Results cannot be held off, so capture rsp on the cycle
// done is high. Unused result fields are zero (date fields for kind 0,
// seconds_out for kind 1). The depth is set by the chain of constant divides
// in the unpack path: seconds by 86400, days by 1461, and seconds of day by
// 3600 and 60, each done as a reciprocal multiply, a back multiply and a
// one-step correction in separate stages.
module rtc_date_seconds_convert_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rdsc_pkg::req_t   req,
	output logic             done,
	output rdsc_pkg::rsp_t   rsp
);
	import rdsc_pkg::*;

	logic accept;

	// valid and kind travel with the data
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6, kind_s7, kind_s8;

	// ---- pack path (kind 0) ----
	logic [15:0] days_a_s1;
	logic [9:0]  days_b_s1;
	logic [16:0] hm_s1;
	logic [5:0]  sec0_s1;
	logic [15:0] days0_s2;
	logic [30:0] hmsadj_s2, hmsadj_s3;
	logic [30:0] prod_s3;
	logic [30:0] secs_s4, secs_s5, secs_s6, secs_s7, secs_s8;

	// ---- unpack path (kind 1) ----
	logic [23:0] x_s1;
	logic [14:0] qday_s1, qday_s2;
	logic [6:0]  lo7_s1, lo7_s2;
	logic [10:0] rday_s2;
	logic [14:0] days_s3, days_s4;
	logic [16:0] sod_s3;
	logic [4:0]  qd_s4, qd_s5;
	logic [12:0] sh_s4;
	logic [4:0]  qh_s4, qh_s5;
	logic [3:0]  sodlo_s4, sodlo_s5;
	logic [11:0] rd_s5;
	logic [8:0]  rh_s5;
	logic [4:0]  q4_s6;
	logic [10:0] d4_s6;
	logic [4:0]  hour_s6, hour_s7, hour_s8;
	logic [11:0] r1_s6;
	logic [6:0]  year_s7, year_s8;
	logic [8:0]  doy_s7, doy_s8;
	logic        leap_s7, leap_s8;
	logic [9:0]  m_s7;
	logic [5:0]  qm_s7, qm_s8;
	logic [1:0]  r1lo_s7, r1lo_s8;
	logic [3:0]  month_s8;
	logic [4:0]  rm_s8;
	rsp_t        rsp_s9;

	// stage 1 combinational terms
	logic [10:0] yr_off;
	logic [3:0]  nmon;
	logic        leap0;
	logic [23:0] x_in;
	logic [38:0] qday_prod;

	// later stage combinational terms
	logic        dayfix, fix4, fixh, fixm;
	logic [19:0] qd_prod;
	logic [17:0] qh_prod;
	logic [16:0] qm_prod;
	logic [1:0]  yig;
	logic [10:0] yig_start;
	logic [3:0]  month_c;
	logic [4:0]  day_c;
	rsp_t        rsp_c;

	// The pipeline never stalls: every request is taken
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---------------- stage 1 ----------------
	// Year offset within the four-year group, in days
	always_comb begin
		unique case (req.in_year[1:0])
			2'd0: yr_off = 11'd0;
			2'd1: yr_off = 11'(DAYS_PER_LEAP);
			2'd2: yr_off = 11'(DAYS_PER_LEAP + DAYS_PER_YEAR);
			2'd3: yr_off = 11'(DAYS_PER_LEAP + 2 * DAYS_PER_YEAR);
			default: yr_off = 11'd0;
		endcase
	end

	// Whole months before this one; month zero counts as January,
	// months past December count the full year
	always_comb begin
		if (req.in_month == 4'd0) begin
			nmon = 4'd0;
		end else if (req.in_month > 4'd13) begin
			nmon = 4'd12;
		end else begin
			nmon = req.in_month - 4'd1;
		end
	end

	assign leap0     = (req.in_year[1:0] == 2'd0);
	assign x_in      = req.seconds_in[30:DAY_SHIFT];
	assign qday_prod = 39'(x_in) * 39'(DAY_RECIP);

	always_ff @(posedge clk) begin
		days_a_s1 <= 16'(req.in_year[6:2]) * 16'(DAYS_PER_QUAD) + 16'(yr_off);
		days_b_s1 <= 10'(month_start(leap0, nmon)) + 10'(req.in_day);
		hm_s1     <= 17'(req.in_hour) * 17'(SECS_PER_HOUR)
		           + 17'(req.in_minute) * 17'(SECS_PER_MIN);
		sec0_s1   <= req.in_second;
		x_s1      <= x_in;
		lo7_s1    <= req.seconds_in[DAY_SHIFT-1:0];
		qday_s1   <= 15'(qday_prod >> DAY_K);
	end

	// ---------------- stage 2 ----------------
	// Sum the day count; fold the day-one offset into the time of day
	always_ff @(posedge clk) begin
		days0_s2  <= days_a_s1 + 16'(days_b_s1);
		hmsadj_s2 <= 31'(hm_s1) + 31'(sec0_s1) - 31'(SECS_PER_DAY);
		rday_s2   <= 11'(x_s1 - 24'(qday_s1) * 24'(DAY_DIV));
		qday_s2   <= qday_s1;
		lo7_s2    <= lo7_s1;
	end

	// ---------------- stage 3 ----------------
	assign dayfix = (rday_s2 >= 11'(DAY_DIV));

	always_ff @(posedge clk) begin
		prod_s3   <= 31'(33'(days0_s2) * 33'(SECS_PER_DAY));
		hmsadj_s3 <= hmsadj_s2;
		days_s3   <= qday_s2 + 15'(dayfix);
		sod_s3    <= {dayfix ? 10'(rday_s2 - 11'(DAY_DIV)) : 10'(rday_s2), lo7_s2};
	end

	// ---------------- stage 4 ----------------
	// Estimate four-year groups and hour of day
	assign qd_prod = 20'(days_s3) * 20'(QUAD_RECIP);
	assign qh_prod = 18'(sod_s3[16:HOUR_SHIFT]) * 18'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		secs_s4  <= prod_s3 + hmsadj_s3;
		qd_s4    <= 5'(qd_prod >> QUAD_K);
		days_s4  <= days_s3;
		qh_s4    <= 5'(qh_prod >> HOUR_K);
		sh_s4    <= sod_s3[16:HOUR_SHIFT];
		sodlo_s4 <= sod_s3[HOUR_SHIFT-1:0];
	end

	// ---------------- stage 5 ----------------
	always_ff @(posedge clk) begin
		secs_s5  <= secs_s4;
		rd_s5    <= 12'(days_s4 - 15'(qd_s4) * 15'(DAYS_PER_QUAD));
		qd_s5    <= qd_s4;
		rh_s5    <= 9'(sh_s4 - 13'(qh_s4) * 13'(HOUR_DIV));
		qh_s5    <= qh_s4;
		sodlo_s5 <= sodlo_s4;
	end

	// ---------------- stage 6 ----------------
	// Correct the estimates by one where the remainder overflows
	assign fix4 = (rd_s5 >= 12'(DAYS_PER_QUAD));
	assign fixh = (rh_s5 >= 9'(HOUR_DIV));

	always_ff @(posedge clk) begin
		secs_s6 <= secs_s5;
		q4_s6   <= qd_s5 + 5'(fix4);
		d4_s6   <= fix4 ? 11'(rd_s5 - 12'(DAYS_PER_QUAD)) : 11'(rd_s5);
		hour_s6 <= qh_s5 + 5'(fixh);
		r1_s6   <= {fixh ? 8'(rh_s5 - 9'(HOUR_DIV)) : 8'(rh_s5), sodlo_s5};
	end

	// ---------------- stage 7 ----------------
	// Year within the group; the leading year is the leap year
	always_comb begin
		if (d4_s6 < 11'(DAYS_PER_LEAP)) begin
			yig       = 2'd0;
			yig_start = 11'd0;
		end else if (d4_s6 < 11'(DAYS_PER_LEAP + DAYS_PER_YEAR)) begin
			yig       = 2'd1;
			yig_start = 11'(DAYS_PER_LEAP);
		end else if (d4_s6 < 11'(DAYS_PER_LEAP + 2 * DAYS_PER_YEAR)) begin
			yig       = 2'd2;
			yig_start = 11'(DAYS_PER_LEAP + DAYS_PER_YEAR);
		end else begin
			yig       = 2'd3;
			yig_start = 11'(DAYS_PER_LEAP + 2 * DAYS_PER_YEAR);
		end
	end

	assign qm_prod = 17'(r1_s6[11:MIN_SHIFT]) * 17'(MIN_RECIP);

	always_ff @(posedge clk) begin
		secs_s7 <= secs_s6;
		year_s7 <= {q4_s6, yig};
		doy_s7  <= 9'(d4_s6 - yig_start);
		leap_s7 <= (yig == 2'd0);
		hour_s7 <= hour_s6;
		m_s7    <= r1_s6[11:MIN_SHIFT];
		qm_s7   <= 6'(qm_prod >> MIN_K);
		r1lo_s7 <= r1_s6[MIN_SHIFT-1:0];
	end

	// ---------------- stage 8 ----------------
	// Month: the last month whose first day is not after the day of year
	always_comb begin
		month_c = 4'd1;
		for (int i = 1; i < 12; i++) begin
			if (doy_s7 >= month_start(leap_s7, 4'(i))) begin
				month_c = 4'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		secs_s8  <= secs_s7;
		year_s8  <= year_s7;
		doy_s8   <= doy_s7;
		leap_s8  <= leap_s7;
		month_s8 <= month_c;
		hour_s8  <= hour_s7;
		qm_s8    <= qm_s7;
		rm_s8    <= 5'(m_s7 - 10'(qm_s7) * 10'(MIN_DIV));
		r1lo_s8  <= r1lo_s7;
	end

	// ---------------- stage 9 ----------------
	// Finish day, minute and second, then select the result by kind
	assign fixm  = (rm_s8 >= 5'(MIN_DIV));
	assign day_c = 5'(doy_s8 - month_start(leap_s8, month_s8 - 4'd1) + 9'd1);

	always_comb begin
		rsp_c = '0;
		if (kind_s8 == KIND_TO_SECONDS) begin
			rsp_c.seconds_out = secs_s8;
		end else begin
			rsp_c.out_year   = year_s8;
			rsp_c.out_month  = month_s8;
			rsp_c.out_day    = day_c;
			rsp_c.out_hour   = hour_s8;
			rsp_c.out_minute = qm_s8 + 6'(fixm);
			rsp_c.out_second = {fixm ? 4'(rm_s8 - 5'(MIN_DIV)) : 4'(rm_s8), r1lo_s8};
		end
	end

	always_ff @(posedge clk) begin
		rsp_s9 <= rsp_c;
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= req.kind;
		kind_s2 <= kind_s1;
		kind_s3 <= kind_s2;
		kind_s4 <= kind_s3;
		kind_s5 <= kind_s4;
		kind_s6 <= kind_s5;
		kind_s7 <= kind_s6;
		kind_s8 <= kind_s7;
	end

	assign done = vld_s9;
	assign rsp  = rsp_s9;

	// ---------------- assertions ----------------
	// A result strobe only ever follows an accepted request
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	// Packing leaves every calendar field at zero
	a_pack_clears_date: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(req.kind, LATENCY) == KIND_TO_SECONDS)) |->
		(rsp.out_year == 7'd0 && rsp.out_month == 4'd0 && rsp.out_day == 5'd0 &&
		 rsp.out_hour == 5'd0 && rsp.out_minute == 6'd0 && rsp.out_second == 6'd0))
		else $error("pack result carries calendar fields");

	// Unpacking gives a date in range, so every divide correction held
	a_unpack_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(req.kind, LATENCY) == KIND_TO_DATE)) |->
		(rsp.seconds_out == 31'd0 && rsp.out_month >= 4'd1 && rsp.out_month <= 4'd12 &&
		 rsp.out_day >= 5'd1 && rsp.out_hour < 5'd24 && rsp.out_minute < 6'd60 &&
		 rsp.out_second < 6'd60 && rsp.out_year <= 7'd68))
		else $error("unpack result out of range");

endmodule
